@@ rtl/emts_pkg.sv @@
`timescale 1ns / 1ps

package emts_pkg;

    // Sound modes, one-hot
    typedef enum logic [5:0] {
        MODE_WAIT    = 6'b000001,
        MODE_START   = 6'b000010,
        MODE_BUTTON  = 6'b000100,
        MODE_PLAYING = 6'b001000,
        MODE_WON     = 6'b010000,
        MODE_LOST    = 6'b100000
    } mode_t;

    localparam logic [3:0]  NOTE_SILENT = 4'd15;
    localparam logic [3:0]  NOTE_MAX    = 4'd14;
    localparam logic [15:0] TOP_SILENT  = 16'hFFFF;

    localparam int WinLen  = 29;
    localparam int LossLen = 7;

    // Timer compare top per note, C4 to C6: floor(62500 / f) - 1
    localparam logic [15:0] NOTE_TOP [15] = '{
        16'd237, 16'd211, 16'd188, 16'd177, 16'd158, 16'd141, 16'd125, 16'd118,
        16'd105, 16'd93,  16'd88,  16'd78,  16'd70,  16'd62,  16'd58
    };

    localparam logic [3:0] WIN_NOTES [WinLen] = '{
        4'd12, 4'd14, 4'd11, 4'd12, 4'd9, 4'd11, 4'd8, 4'd9, 4'd7, 4'd8,
        4'd5,  4'd7,  4'd4,  4'd5,  4'd2, 4'd4,  4'd1, 4'd2, 4'd0, 4'd1,
        4'd2,  4'd4,  4'd5,  4'd7,  4'd8, 4'd9,  4'd11, 4'd12, 4'd14
    };

    localparam logic [3:0] LOSS_NOTES [LossLen] = '{
        4'd14, 4'd13, 4'd12, 4'd9, 4'd7, 4'd6, 4'd5
    };

    // Sequencer state
    typedef struct packed {
        mode_t      mode;
        logic [4:0] pos;
        logic [4:0] ticks;
        logic [3:0] level;
        logic [3:0] last;
        logic       song;
    } seq_state_t;

    // One result item
    typedef struct packed {
        logic        tone_on;
        logic [15:0] compare_top;
        logic        counter_restart;
        logic        song_playing;
    } seq_result_t;

    // Number of notes in a melody
    function automatic logic [4:0] melody_len(mode_t m);
        case (m)
            MODE_START:  return 5'd3;
            MODE_BUTTON: return 5'd2;
            MODE_WON:    return 5'(WinLen);
            MODE_LOST:   return 5'(LossLen);
            default:     return 5'd0;
        endcase
    endfunction

    // Note index at a position, silent past the end
    function automatic logic [3:0] melody_note(mode_t m, logic [4:0] pos, logic [3:0] lvl);
        logic [4:0] cue;
        logic [3:0] n;
        cue = {1'b0, lvl} + ((pos == 5'd0) ? 5'd1 : 5'd6);
        n   = NOTE_SILENT;
        if (pos < melody_len(m)) begin
            case (m)
                MODE_START:
                begin
                    case (pos[1:0])
                        2'd0:    n = 4'd7;
                        2'd1:    n = 4'd12;
                        default: n = 4'd11;
                    endcase
                end
                MODE_BUTTON: n = (cue > {1'b0, NOTE_MAX}) ? NOTE_MAX : cue[3:0];
                MODE_WON:    n = WIN_NOTES[pos];
                MODE_LOST:   n = LOSS_NOTES[pos[2:0]];
                default:     n = NOTE_SILENT;
            endcase
        end
        return n;
    endfunction

    // Duration in ticks at a position, zero past the end
    function automatic logic [4:0] melody_ticks(mode_t m, logic [4:0] pos);
        logic [4:0] t;
        t = 5'd0;
        if (pos < melody_len(m)) begin
            case (m)
                MODE_START:  t = (pos == 5'd2) ? 5'd4 : 5'd2;
                MODE_BUTTON: t = (pos == 5'd0) ? 5'd2 : 5'd4;
                MODE_WON:    t = 5'd2;
                MODE_LOST:   t = (pos == 5'd6) ? 5'd18 : 5'd6;
                default:     t = 5'd0;
            endcase
        end
        return t;
    endfunction

endpackage

@@ rtl/emts_step.sv @@
`timescale 1ns / 1ps

module emts_step (
    input  emts_pkg::seq_state_t  cur,
    input  logic                  start_flag,
    input  logic                  won_flag,
    input  logic                  lost_flag,
    input  logic                  button_pressed,
    input  logic [3:0]            game_level,
    output emts_pkg::seq_state_t  nxt,
    output emts_pkg::seq_result_t res
);
    import emts_pkg::*;

    seq_state_t mid;
    logic       melody;
    logic [3:0] note;
    logic [4:0] tick_dec;
    logic [4:0] pos_inc;

    // Mode transitions
    always_comb
    begin
        mid = cur;
        case (cur.mode)
            MODE_WAIT:
            begin
                if (start_flag) begin
                    mid.mode  = MODE_START;
                    mid.last  = NOTE_SILENT;
                    mid.pos   = 5'd0;
                    mid.ticks = melody_ticks(MODE_START, 5'd0);
                end
            end
            MODE_PLAYING:
            begin
                if (button_pressed) begin
                    mid.level = game_level;
                    mid.mode  = MODE_BUTTON;
                    mid.last  = NOTE_SILENT;
                    mid.pos   = 5'd0;
                    mid.ticks = melody_ticks(MODE_BUTTON, 5'd0);
                end else if (won_flag) begin
                    mid.song  = 1'b1;
                    mid.mode  = MODE_WON;
                    mid.last  = NOTE_SILENT;
                    mid.pos   = 5'd0;
                    mid.ticks = melody_ticks(MODE_WON, 5'd0);
                end else if (lost_flag) begin
                    mid.song  = 1'b1;
                    mid.mode  = MODE_LOST;
                    mid.last  = NOTE_SILENT;
                    mid.pos   = 5'd0;
                    mid.ticks = melody_ticks(MODE_LOST, 5'd0);
                end
            end
            MODE_START, MODE_BUTTON:
            begin
                if (cur.pos >= melody_len(cur.mode)) begin
                    mid.mode = MODE_PLAYING;
                end
            end
            MODE_WON, MODE_LOST:
            begin
                if (cur.pos >= melody_len(cur.mode)) begin
                    mid.song = 1'b0;
                    mid.mode = MODE_WAIT;
                end
            end
            default:
            begin
                mid = cur;
            end
        endcase
    end

    // Note playback
    assign melody   = (mid.mode == MODE_START) || (mid.mode == MODE_BUTTON) ||
                      (mid.mode == MODE_WON)   || (mid.mode == MODE_LOST);
    assign note     = melody_note(mid.mode, mid.pos, mid.level);
    assign tick_dec = mid.ticks - 5'd1;
    assign pos_inc  = mid.pos + 5'd1;

    always_comb
    begin
        nxt                 = mid;
        res.tone_on         = 1'b0;
        res.compare_top     = TOP_SILENT;
        res.counter_restart = 1'b0;
        if (melody && (note <= NOTE_MAX)) begin
            res.tone_on         = 1'b1;
            res.compare_top     = NOTE_TOP[note];
            res.counter_restart = (note != mid.last);
            nxt.last            = note;
            nxt.ticks           = tick_dec;
            if (tick_dec == 5'd0) begin
                nxt.pos   = pos_inc;
                nxt.ticks = melody_ticks(mid.mode, pos_inc);
            end
        end
        res.song_playing = mid.song;
    end

endmodule

@@ rtl/event_melody_tone_sequencer_core.sv @@
`timescale 1ns / 1ps

// Buzzer melody sequencer. Each item on the input channel is one tick carrying
// the start, won, lost and button flags and the game level; each tick yields
// exactly one result item: tone enable, 16-bit timer compare top, counter
// restart and song-playing flag.
// Channels: item_valid/item_ready in, result_valid/result_ready out, both
// plain valid/ready, transfer when both are high.
// An accepted item is held in the input register and its result is then
// registered in the result register, which raises result_valid.
// Throughput: one item per cycle while the receiver takes results, limited
// only by the combinational step logic between the input and result registers.
// Reset (rst_n low) puts the sequencer in wait-for-start, silent, with both
// pipeline registers empty.
// When the receiver stalls, the result register holds; one more item may be
// taken into the input register, after which item_ready drops until the
// result is taken. Sequencer state only advances when a result is produced.
module event_melody_tone_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        start_flag,
    input  logic        won_flag,
    input  logic        lost_flag,
    input  logic        button_pressed,
    input  logic [3:0]  game_level,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        tone_on,
    output logic [15:0] compare_top,
    output logic        counter_restart,
    output logic        song_playing
);
    import emts_pkg::*;

    logic        in_full_reg;
    logic        start_reg;
    logic        won_reg;
    logic        lost_reg;
    logic        button_reg;
    logic [3:0]  level_reg;
    seq_state_t  state_reg;
    seq_state_t  state_next;
    seq_result_t res_next;
    seq_result_t res_reg;
    logic        out_full_reg;
    logic        advance;

    // Step when an item is held and the result slot is free or draining
    assign advance    = in_full_reg && (!out_full_reg || result_ready);
    assign item_ready = !in_full_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_full_reg <= 1'b0;
        end else if (item_ready) begin
            in_full_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready) begin
            start_reg  <= start_flag;
            won_reg    <= won_flag;
            lost_reg   <= lost_flag;
            button_reg <= button_pressed;
            level_reg  <= game_level;
        end
    end

    // Tick step logic
    emts_step u_step (
        .cur            (state_reg),
        .start_flag     (start_reg),
        .won_flag       (won_reg),
        .lost_flag      (lost_reg),
        .button_pressed (button_reg),
        .game_level     (level_reg),
        .nxt            (state_next),
        .res            (res_next)
    );

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.mode  <= MODE_WAIT;
            state_reg.pos   <= 5'd0;
            state_reg.ticks <= 5'd0;
            state_reg.level <= 4'd0;
            state_reg.last  <= NOTE_SILENT;
            state_reg.song  <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_full_reg <= 1'b0;
        end else if (advance) begin
            out_full_reg <= 1'b1;
        end else if (result_ready) begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign result_valid    = out_full_reg;
    assign tone_on         = res_reg.tone_on;
    assign compare_top     = res_reg.compare_top;
    assign counter_restart = res_reg.counter_restart;
    assign song_playing    = res_reg.song_playing;

endmodule

@@ bench/event_melody_tone_sequencer_core_tb.sv @@
`timescale 1ns / 1ps

module event_melody_tone_sequencer_core_tb;

    import emts_pkg::*;

    localparam int RANDOM_TICKS     = 1900;
    localparam int LONG_HOLD_AT     = 600;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT       = 3000;
    localparam int DRAIN_CYCLES     = 10;

    localparam logic [4:0]  QUIET_NOTE = 5'd15;
    localparam logic [15:0] QUIET_TOP  = 16'hFFFF;

    // Compare tops for C4 up to C6
    localparam logic [15:0] TOP_BY_NOTE [15] = '{
        16'd237, 16'd211, 16'd188, 16'd177, 16'd158, 16'd141, 16'd125, 16'd118,
        16'd105, 16'd93,  16'd88,  16'd78,  16'd70,  16'd62,  16'd58
    };
    localparam logic [4:0] WIN_TUNE [29] = '{
        5'd12, 5'd14, 5'd11, 5'd12, 5'd9, 5'd11, 5'd8, 5'd9, 5'd7, 5'd8,
        5'd5,  5'd7,  5'd4,  5'd5,  5'd2, 5'd4,  5'd1, 5'd2, 5'd0, 5'd1,
        5'd2,  5'd4,  5'd5,  5'd7,  5'd8, 5'd9,  5'd11, 5'd12, 5'd14
    };
    localparam logic [4:0] LOSS_TUNE [7]     = '{5'd14, 5'd13, 5'd12, 5'd9, 5'd7, 5'd6, 5'd5};
    localparam logic [4:0] LOSS_DURATION [7] = '{5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd18};
    localparam logic [4:0] JINGLE_TUNE [3]   = '{5'd7, 5'd12, 5'd11};
    localparam logic [4:0] JINGLE_DURATION [3] = '{5'd2, 5'd2, 5'd4};

    typedef struct {
        logic       start;
        logic       won;
        logic       lost;
        logic       button;
        logic [3:0] level;
        bit         drain;
    } tick_t;

    typedef struct packed {
        logic        tone;
        logic [15:0] top;
        logic        restart;
        logic        song;
    } tone_result_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid     = 1'b0;
    logic        item_ready;
    logic        start_flag     = 1'b0;
    logic        won_flag       = 1'b0;
    logic        lost_flag      = 1'b0;
    logic        button_pressed = 1'b0;
    logic [3:0]  game_level     = 4'd0;
    logic        result_valid;
    logic        result_ready   = 1'b0;
    logic        tone_on;
    logic [15:0] compare_top;
    logic        counter_restart;
    logic        song_playing;

    event_melody_tone_sequencer_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .start_flag      (start_flag),
        .won_flag        (won_flag),
        .lost_flag       (lost_flag),
        .button_pressed  (button_pressed),
        .game_level      (game_level),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .tone_on         (tone_on),
        .compare_top     (compare_top),
        .counter_restart (counter_restart),
        .song_playing    (song_playing)
    );

    // Sequencer state as seen by the predictor
    mode_t      tune_mode     = MODE_WAIT;
    logic [4:0] tune_pos      = 5'd0;
    logic [4:0] ticks_to_go   = 5'd0;
    logic [3:0] cue_level     = 4'd0;
    logic [4:0] prev_note     = QUIET_NOTE;
    logic       song_on       = 1'b0;

    tick_t        tick_q[$];
    tick_t        cur_tick;
    tone_result_t predicted_tones[$];

    int total_ticks;
    int items_sent    = 0;
    int results_seen  = 0;
    int errors        = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int idle_cycles   = 0;
    int jingles       = 0;
    int cues          = 0;
    int win_songs     = 0;
    int loss_songs    = 0;
    int restarts      = 0;

    // Melody tables
    function automatic logic [4:0] tune_length(input mode_t m);
        case (m)
            MODE_START:  return 5'd3;
            MODE_BUTTON: return 5'd2;
            MODE_WON:    return 5'd29;
            MODE_LOST:   return 5'd7;
            default:     return 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] tune_note(input mode_t m, input logic [4:0] pos);
        logic [4:0] raw;
        if (pos >= tune_length(m))
            return QUIET_NOTE;
        case (m)
            MODE_START:  return JINGLE_TUNE[pos[1:0]];
            MODE_BUTTON:
            begin
                raw = {1'b0, cue_level} + ((pos == 5'd0) ? 5'd1 : 5'd6);
                return (raw > 5'd14) ? 5'd14 : raw;
            end
            MODE_WON:    return WIN_TUNE[pos];
            MODE_LOST:   return LOSS_TUNE[pos[2:0]];
            default:     return QUIET_NOTE;
        endcase
    endfunction

    function automatic logic [4:0] tune_duration(input mode_t m, input logic [4:0] pos);
        if (pos >= tune_length(m))
            return 5'd0;
        case (m)
            MODE_START:  return JINGLE_DURATION[pos[1:0]];
            MODE_BUTTON: return (pos == 5'd0) ? 5'd2 : 5'd4;
            MODE_WON:    return 5'd2;
            MODE_LOST:   return LOSS_DURATION[pos[2:0]];
            default:     return 5'd0;
        endcase
    endfunction

    // Timer goes silent first so the opening note always restarts the counter
    function automatic void enter_tune(input mode_t m);
        tune_mode   = m;
        prev_note   = QUIET_NOTE;
        tune_pos    = 5'd0;
        ticks_to_go = tune_duration(m, 5'd0);
        case (m)
            MODE_START:  jingles++;
            MODE_BUTTON: cues++;
            MODE_WON:    win_songs++;
            default:     loss_songs++;
        endcase
    endfunction

    // One tick of the sequencer
    function automatic tone_result_t predict_tick(input tick_t t);
        tone_result_t r;
        logic [4:0]   note;
        r.tone    = 1'b0;
        r.top     = QUIET_TOP;
        r.restart = 1'b0;

        case (tune_mode)
            MODE_WAIT:
                if (t.start)
                    enter_tune(MODE_START);
            MODE_PLAYING:
            begin
                if (t.button)
                begin
                    cue_level = t.level;
                    enter_tune(MODE_BUTTON);
                end
                else if (t.won)
                begin
                    song_on = 1'b1;
                    enter_tune(MODE_WON);
                end
                else if (t.lost)
                begin
                    song_on = 1'b1;
                    enter_tune(MODE_LOST);
                end
            end
            MODE_START, MODE_BUTTON:
                if (tune_pos >= tune_length(tune_mode))
                    tune_mode = MODE_PLAYING;
            MODE_WON, MODE_LOST:
                if (tune_pos >= tune_length(tune_mode))
                begin
                    song_on   = 1'b0;
                    tune_mode = MODE_WAIT;
                end
            default: ;
        endcase

        if (tune_mode == MODE_START || tune_mode == MODE_BUTTON ||
            tune_mode == MODE_WON || tune_mode == MODE_LOST)
        begin
            note = tune_note(tune_mode, tune_pos);
            if (note <= 5'd14)
            begin
                r.tone      = 1'b1;
                r.top       = TOP_BY_NOTE[note[3:0]];
                r.restart   = (note != prev_note);
                restarts   += int'(r.restart);
                prev_note   = note;
                ticks_to_go = ticks_to_go - 5'd1;
                if (ticks_to_go == 5'd0)
                begin
                    tune_pos    = tune_pos + 5'd1;
                    ticks_to_go = tune_duration(tune_mode, tune_pos);
                end
            end
        end
        r.song = song_on;
        return r;
    endfunction

    function automatic void add_tick(input bit s, input bit w, input bit l, input bit b,
                                     input bit [3:0] lvl, input bit drain);
        tick_t t;
        t.start  = s;
        t.won    = w;
        t.lost   = l;
        t.button = b;
        t.level  = lvl;
        t.drain  = drain;
        tick_q.push_back(t);
    endfunction

    // Idle cycles before the next item; style changes every 64 items
    function automatic int draw_gap(input int n);
        case ((n / 64) % 4)
            0:       return 0;
            1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            2:       return $urandom_range(0, 16);
            default: return $urandom_range(0, 2);
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Reset, once
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: offers queued ticks, predicts each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin : driver
        bit fired;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            gap_left   <= 0;
        end
        else
        begin
            fired = item_valid && item_ready;
            if (fired)
            begin
                predicted_tones.push_back(predict_tick(cur_tick));
                items_sent++;
            end
            if (!item_valid || fired)
            begin
                if (gap_left > 0)
                begin
                    item_valid <= 1'b0;
                    gap_left   <= gap_left - 1;
                end
                else if (tick_q.size() != 0 &&
                         !(tick_q[0].drain && predicted_tones.size() != 0))
                begin
                    cur_tick = tick_q.pop_front();
                    start_flag     <= cur_tick.start;
                    won_flag       <= cur_tick.won;
                    lost_flag      <= cur_tick.lost;
                    button_pressed <= cur_tick.button;
                    game_level     <= cur_tick.level;
                    item_valid     <= 1'b1;
                    gap_left       <= draw_gap(items_sent);
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result item against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : monitor
        tone_result_t want;
        int           wait_now;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            wait_now = stall_left;
            if (result_valid && result_ready)
            begin
                if (predicted_tones.size() == 0)
                begin
                    $error("result item with nothing predicted");
                    errors++;
                end
                else
                begin
                    want = predicted_tones.pop_front();
                    check_field("tone_on", 16'(want.tone), 16'(tone_on));
                    check_field("compare_top", want.top, compare_top);
                    check_field("counter_restart", 16'(want.restart),
                                16'(counter_restart));
                    check_field("song_playing", 16'(want.song), 16'(song_playing));
                end
                results_seen++;
                // one long hold so the block backs up into its input
                wait_now = (results_seen == LONG_HOLD_AT) ? LONG_HOLD_CYCLES
                                                          : draw_gap(results_seen);
            end
            if (wait_now > 0)
            begin
                result_ready <= 1'b0;
                stall_left   <= wait_now - 1;
            end
            else
            begin
                result_ready <= 1'b1;
                stall_left   <= 0;
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int n;
        int len;
        int held;
        int k;
        bit is_win;
        bit drain;
        bit first;

        // quiet tick, then events ignored while waiting for start
        add_tick(0, 0, 0, 0, 4'd0, 0);
        add_tick(0, 1, 1, 1, 4'd15, 0);
        // start jingle, eight ticks; flags ignored meanwhile
        add_tick(1, 0, 0, 0, 4'd15, 0);
        add_tick(1, 1, 0, 1, 4'd7, 0);
        add_tick(0, 0, 1, 1, 4'd8, 0);
        add_tick(1, 1, 1, 0, 4'd0, 0);
        add_tick(0, 0, 0, 1, 4'd15, 0);
        add_tick(1, 0, 1, 0, 4'd3, 0);
        add_tick(0, 1, 0, 0, 4'd12, 0);
        add_tick(1, 0, 0, 1, 4'd5, 0);
        // past the last note: back to play, silent
        add_tick(0, 0, 0, 0, 4'd0, 0);
        // button beats won and lost; top level clamps both cue notes to the top
        add_tick(1, 1, 1, 1, 4'd15, 0);
        add_tick(1, 0, 0, 0, 4'd10, 0);
        add_tick(1, 0, 0, 1, 4'd15, 0);
        add_tick(1, 1, 0, 0, 4'd15, 0);
        add_tick(1, 0, 1, 0, 4'd15, 0);
        add_tick(1, 0, 0, 0, 4'd15, 0);
        add_tick(1, 0, 0, 0, 4'd15, 0);
        // lowest level cue
        add_tick(1, 0, 0, 1, 4'd0, 0);
        add_tick(1, 0, 0, 0, 4'd0, 0);
        add_tick(1, 0, 0, 0, 4'd0, 0);
        add_tick(1, 0, 0, 0, 4'd0, 0);
        add_tick(1, 0, 0, 0, 4'd0, 0);
        add_tick(1, 0, 0, 0, 4'd0, 0);
        add_tick(1, 0, 0, 0, 4'd0, 0);

        // random games: start, play with button cues, win or loss, song tail; mixed with bursts of random flags
        n     = tick_q.size();
        first = 1'b1;
        while (tick_q.size() - n < RANDOM_TICKS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                len = $urandom_range(5, 40);
                repeat (len)
                    add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             4'($urandom_range(0, 15)), 0);
            end
            else
            begin
                drain = first || ($urandom_range(0, 7) == 0);
                first = 1'b0;
                len   = $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                    add_tick(1, 0, 0, $urandom_range(0, 5) == 0, 4'($urandom_range(0, 15)),
                             drain && k == 0);
                len = $urandom_range(12, 50);
                repeat (len)
                    add_tick(1, $urandom_range(0, 30) == 0, $urandom_range(0, 30) == 0,
                             $urandom_range(0, 6) == 0, 4'($urandom_range(0, 15)), 0);
                // held long enough to outlast a button cue, sometimes only a pulse
                is_win = 1'($urandom_range(0, 1));
                held   = ($urandom_range(0, 3) == 0) ? 1 : 8;
                repeat (held)
                    add_tick(1, is_win, !is_win || ($urandom_range(0, 3) == 0), 0,
                             4'($urandom_range(0, 15)), 0);
                len = $urandom_range(55, 80);
                repeat (len)
                    add_tick(0, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                             $urandom_range(0, 3) == 0, 4'($urandom_range(0, 15)), 0);
            end
        end
        total_ticks = tick_q.size();

        while (items_sent != total_ticks || predicted_tones.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d ticks, %0d results checked; %0d jingles, %0d button cues,",
                 items_sent, results_seen, jingles, cues);
        $display("%0d win songs, %0d loss songs, %0d counter restarts.",
                 win_songs, loss_songs, restarts);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
